FILE: design/pit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared widths for the point-in-tetrahedron determinant pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;
  localparam int COORD_BITS    = 16;
  localparam int TOL_FRAC_BITS = 24;
  localparam int TOL_BITS      = 24;
  localparam int PT_BITS       = 48;
  // edge vector components: difference of two coordinates
  localparam int DIFF_BITS     = COORD_BITS + 1;
  // 2x2 minors
  localparam int MIN_BITS      = 2 * DIFF_BITS + 1;
  // products of one component and one minor, and 3x3 determinant
  localparam int PROD_BITS     = DIFF_BITS + MIN_BITS;
  localparam int DET_BITS      = PROD_BITS + 2;
  // scaled sub-determinant plus margin
  localparam int CMP_BITS      = DET_BITS + TOL_FRAC_BITS + 2;
  // |D| is split in two halves for the margin product
  localparam int MAG_LO_BITS   = DET_BITS / 2;
  localparam int MAG_HI_BITS   = DET_BITS - MAG_LO_BITS;
  localparam int PART_BITS     = MAG_HI_BITS + TOL_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [MIN_BITS-1:0]   minor_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DET_BITS-1:0]   det_t;
  typedef logic signed [CMP_BITS-1:0]   cmp_t;
  typedef logic [PART_BITS-1:0]         part_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;
endpackage

FILE: design/point_in_tetrahedron_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// 7 register stages; one word per cycle while the output is not stalled.
// Stages: edge vectors, 2x2 minors, triple products, determinant sums,
// sign correction and split margin products, margin sum, compare and output.
// Stalls freeze the whole pipeline together (one multiplier deep per stage).
// Reset: synchronous, clears valid bits and tolerance to 0.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test
  import pit_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertex_a, vertex_b, vertex_c, vertex_d, query_point (lowest bits first)
  input  logic [239:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res, degenerate (lowest bit first), zero filled
  output logic [7:0]   m_tdata
);
  localparam int NST = 7;

  logic [TOL_BITS-1:0] tolerance;
  logic [NST-1:0]      vld;
  logic                adv;

  // pipeline moves when the output slot is free or taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata[TOL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // ---- stage 1: edge vectors. set k uses query point in place of vertex k
  // set 0 total: (a,b,c,d); set 1..4 replace a,b,c,d
  function automatic vec_t vsub(input logic [PT_BITS-1:0] p, input logic [PT_BITS-1:0] q);
    vec_t r;
    r.x = DIFF_BITS'(coord_t'(p[3*COORD_BITS-1:2*COORD_BITS]))
        - DIFF_BITS'(coord_t'(q[3*COORD_BITS-1:2*COORD_BITS]));
    r.y = DIFF_BITS'(coord_t'(p[2*COORD_BITS-1:COORD_BITS]))
        - DIFF_BITS'(coord_t'(q[2*COORD_BITS-1:COORD_BITS]));
    r.z = DIFF_BITS'(coord_t'(p[COORD_BITS-1:0]))
        - DIFF_BITS'(coord_t'(q[COORD_BITS-1:0]));
    return r;
  endfunction

  logic [PT_BITS-1:0] pt [5];
  vec_t u1 [5], v1 [5], w1 [5];

  always_comb begin
    for (int i = 0; i < 5; i++) pt[i] = s_tdata[i*PT_BITS +: PT_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 5; k++) begin
        logic [PT_BITS-1:0] q [4];
        for (int i = 0; i < 4; i++) q[i] = pt[i];
        if (k > 0) q[k-1] = pt[4];
        u1[k] <= vsub(q[1], q[0]);
        v1[k] <= vsub(q[2], q[0]);
        w1[k] <= vsub(q[3], q[0]);
      end
    end
  end

  // ---- stage 2: 2x2 minors of v, w
  vec_t   u2 [5];
  minor_t m0 [5], m1 [5], m2 [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 5; k++) begin
        u2[k] <= u1[k];
        m0[k] <= MIN_BITS'(v1[k].y) * MIN_BITS'(w1[k].z)
               - MIN_BITS'(v1[k].z) * MIN_BITS'(w1[k].y);
        m1[k] <= MIN_BITS'(v1[k].x) * MIN_BITS'(w1[k].z)
               - MIN_BITS'(v1[k].z) * MIN_BITS'(w1[k].x);
        m2[k] <= MIN_BITS'(v1[k].x) * MIN_BITS'(w1[k].y)
               - MIN_BITS'(v1[k].y) * MIN_BITS'(w1[k].x);
      end
    end
  end

  // ---- stage 3: triple products
  prod_t p0 [5], p1 [5], p2 [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 5; k++) begin
        p0[k] <= PROD_BITS'(u2[k].x) * PROD_BITS'(m0[k]);
        p1[k] <= PROD_BITS'(u2[k].y) * PROD_BITS'(m1[k]);
        p2[k] <= PROD_BITS'(u2[k].z) * PROD_BITS'(m2[k]);
      end
    end
  end

  // ---- stage 4: determinants, negated (4x4 = -det3)
  det_t det [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 5; k++) begin
        det[k] <= DET_BITS'(p1[k]) - DET_BITS'(p0[k]) - DET_BITS'(p2[k]);
      end
    end
  end

  // ---- stage 5: sign-correct, tol * |D| as two half-width products
  logic neg4, zero4;
  det_t mag4;
  assign neg4  = det[0][DET_BITS-1];
  assign zero4 = (det[0] == '0);
  assign mag4  = neg4 ? -det[0] : det[0];

  part_t plo5, phi5;
  det_t  sub5 [4];
  logic  zero5;

  always_ff @(posedge clk) begin
    if (adv) begin
      plo5 <= PART_BITS'(mag4[MAG_LO_BITS-1:0]) * PART_BITS'(tolerance);
      phi5 <= PART_BITS'(mag4[DET_BITS-1:MAG_LO_BITS]) * PART_BITS'(tolerance);
      for (int k = 0; k < 4; k++) sub5[k] <= neg4 ? -det[k+1] : det[k+1];
      zero5 <= zero4;
    end
  end

  // ---- stage 6: margin = tol * |D|
  cmp_t margin6;
  det_t sub6 [4];
  logic zero6;

  always_ff @(posedge clk) begin
    if (adv) begin
      margin6 <= (CMP_BITS'(phi5) << MAG_LO_BITS) + CMP_BITS'(plo5);
      for (int k = 0; k < 4; k++) sub6[k] <= sub5[k];
      zero6 <= zero5;
    end
  end

  // ---- stage 7: compare and output register
  logic ok7;
  always_comb begin
    ok7 = 1'b1;
    for (int k = 0; k < 4; k++) begin
      cmp_t lhs;
      lhs = (CMP_BITS'(sub6[k]) <<< TOL_FRAC_BITS) + margin6;
      if (lhs[CMP_BITS-1] || lhs == '0) ok7 = 1'b0;
    end
  end

  logic inside_res, degenerate;
  always_ff @(posedge clk) begin
    if (adv) begin
      inside_res <= ok7 && !zero6;
      degenerate <= zero6;
    end
  end

  assign m_tdata = {6'b0, degenerate, inside_res};
endmodule

FILE: design/pit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks for the point-in-tetrahedron pipeline.
// ----------------------------------------------------------------------------
module pit_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  // degenerate word never reports inside
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1])) else $error("inside on flat");
  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("word dropped");
  // input ready whenever output is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("needless stall");
  // nothing out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind point_in_tetrahedron_test pit_checker u_pit_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point-in-tetrahedron determinant test. Words of
// four vertices and a query point go in, and each result word is checked
// against an exact integer prediction of inside and degenerate flags.
// ----------------------------------------------------------------------------
module tb_top;
  import pit_pkg::*;

  localparam int LATENCY   = 7;
  localparam int WDOG_MAX  = 5000;

  typedef struct packed {
    logic hit;
    logic degen;
  } verdict_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [23:0]  cfg_wdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [239:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [7:0]   m_tdata;

  logic [23:0]  tol_shadow = '0;
  verdict_t     verdict_q[$];
  int           errors = 0;
  int           words_sent = 0;
  int           words_checked = 0;
  int           degen_seen = 0;
  int           inside_seen = 0;
  int           idle_cycles = 0;

  point_in_tetrahedron_test i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // signed coordinate from a packed point, slot 2 = x, 1 = y, 0 = z
  function automatic longint crd(logic [47:0] p, int slot);
    logic signed [15:0] v;
    v = p[slot*16 +: 16];
    return longint'(v);
  endfunction

  // 4x4 point determinant = -det3(b-a, c-a, d-a), exact in 128 bits
  function automatic logic signed [127:0] point_det(logic [47:0] a, logic [47:0] b,
                                                     logic [47:0] c, logic [47:0] d);
    longint u[3], v[3], w[3];
    logic signed [127:0] m0, m1, m2, t;
    for (int i = 0; i < 3; i++) begin
      u[i] = crd(b, 2-i) - crd(a, 2-i);
      v[i] = crd(c, 2-i) - crd(a, 2-i);
      w[i] = crd(d, 2-i) - crd(a, 2-i);
    end
    m0 = v[1]*w[2] - v[2]*w[1];
    m1 = v[0]*w[2] - v[2]*w[0];
    m2 = v[0]*w[1] - v[1]*w[0];
    t = 128'(signed'(u[0])) * m0 - 128'(signed'(u[1])) * m1
      + 128'(signed'(u[2])) * m2;
    return -t;
  endfunction

  function automatic verdict_t classify_point(logic [239:0] w);
    logic [47:0] p[5], q[4];
    logic signed [127:0] total, mag, margin, sub, lhs;
    verdict_t r;
    for (int i = 0; i < 5; i++) p[i] = w[i*48 +: 48];
    total = point_det(p[0], p[1], p[2], p[3]);
    r.degen = (total == 0);
    r.hit = !r.degen;
    if (r.degen) return r;
    mag = total < 0 ? -total : total;
    margin = mag * $signed({104'd0, tol_shadow});
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) q[i] = p[i];
      q[k] = p[4];
      sub = point_det(q[0], q[1], q[2], q[3]);
      if (total < 0) sub = -sub;
      lhs = (sub <<< TOL_FRAC_BITS) + margin;
      if (lhs <= 0) r.hit = 0;
    end
    return r;
  endfunction

  // send one word after a random gap; valid stays up when no gap follows
  task automatic send_word(logic [239:0] w, int max_gap = 10);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= w;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    verdict_q = {verdict_q, classify_point(w)};
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_tolerance(logic [23:0] t);
    drain();
    cfg_wdata <= t;
    cfg_we    <= 1;
    @(negedge clk);
    cfg_we    <= 0;
    tol_shadow = t;
  endtask

  function automatic logic [47:0] mk_pt(int x, int y, int z);
    return {16'(x), 16'(y), 16'(z)};
  endfunction

  function automatic logic [47:0] rnd_pt();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic int rc(int lim);
    return $urandom_range(0, 2*lim) - lim;
  endfunction

  // random tetrahedron with a query point near it
  function automatic logic [239:0] rnd_case(int lim);
    logic [47:0] v[4];
    int cx, cy, cz;
    for (int i = 0; i < 4; i++) v[i] = mk_pt(rc(lim), rc(lim), rc(lim));
    cx = int'((crd(v[0],2)+crd(v[1],2)+crd(v[2],2)+crd(v[3],2))/4) + rc(lim/2);
    cy = int'((crd(v[0],1)+crd(v[1],1)+crd(v[2],1)+crd(v[3],1))/4) + rc(lim/2);
    cz = int'((crd(v[0],0)+crd(v[1],0)+crd(v[2],0)+crd(v[3],0))/4) + rc(lim/2);
    return {mk_pt(cx, cy, cz), v[3], v[2], v[1], v[0]};
  endfunction

  // corners, faces, extremes, flat shapes
  task automatic test_directed();
    logic [47:0] o, ex, ey, ez;
    o = mk_pt(0,0,0); ex = mk_pt(100,0,0); ey = mk_pt(0,100,0); ez = mk_pt(0,0,100);
    send_word({mk_pt(10,10,10), ez, ey, ex, o});
    send_word({mk_pt(10,10,10), ey, ez, ex, o});      // negative orientation
    send_word({mk_pt(-1,10,10), ez, ey, ex, o});
    send_word({mk_pt(0,10,10), ez, ey, ex, o});       // on a face
    send_word({o, ez, ey, ex, o});                    // at a vertex
    send_word({mk_pt(5,5,5), mk_pt(200,0,0), ey, ex, o}); // flat
    send_word({mk_pt(1,1,1), o, o, o, o});            // all vertices equal
    send_word({48'h7fff_7fff_7fff, mk_pt(-32768,-32768,32767),
               mk_pt(-32768,32767,-32768), mk_pt(32767,-32768,-32768),
               48'h8000_8000_8000});
    send_word({48'h0, 48'h7fff_7fff_8000, 48'h7fff_8000_7fff,
               48'h8000_7fff_7fff, 48'h8000_8000_8000});
    send_word({48'hffff_ffff_ffff, 48'h0000_0000_7fff, 48'h0000_7fff_0000,
               48'h7fff_0000_0000, 48'h8000_8000_8000});
    send_word('1);
    send_word({5{48'h5555_aaaa_5555}});
    send_word({5{48'haaaa_5555_aaaa}});
  endtask

  task automatic test_tolerance_sweep();
    logic [23:0] tols[4] = '{24'hffffff, 24'h000001, 24'h800000, 24'h0};
    foreach (tols[t]) begin
      set_tolerance(tols[t]);
      send_word({mk_pt(-1,10,10), mk_pt(0,0,100), mk_pt(0,100,0),
                 mk_pt(100,0,0), mk_pt(0,0,0)});
      send_word({mk_pt(0,10,10), mk_pt(0,0,100), mk_pt(0,100,0),
                 mk_pt(100,0,0), mk_pt(0,0,0)});
      for (int i = 0; i < 40; i++) send_word(rnd_case(50));
    end
  endtask

  task automatic test_random();
    int sel;
    for (int i = 0; i < 1100; i++) begin
      if (i % 300 == 150) set_tolerance(24'($urandom()));
      if (i == 500) drain();   // sender holds until all results are back
      sel = $urandom_range(0, 9);
      if (sel < 5)       send_word(rnd_case(30), (i % 200 < 40) ? 0 : 10);
      else if (sel < 7)  send_word(rnd_case(32000), 10);
      else if (sel < 8)  send_word({rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt()});
      else begin
        logic [239:0] w;
        w = rnd_case(20);
        w[191:144] = w[47:0] + 48'($urandom_range(0,1));  // near flat
        send_word(w);
      end
    end
  endtask

  // result side: random wait per word, compare with oldest prediction
  initial begin
    verdict_t got, want;
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || !m_tvalid);
      got.hit   = m_tdata[0];
      got.degen = m_tdata[1];
      if (verdict_q.size() == 0) begin
        $display("%0t: result word with no prediction waiting: %b", $time, m_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        words_checked++;
        if (want.degen) degen_seen++;
        if (want.hit) inside_seen++;
        if (got.hit !== want.hit) begin
          $display("%0t: inside mismatch: expected %b actual %b", $time,
                   want.hit, got.hit);
          errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate mismatch: expected %b actual %b", $time,
                   want.degen, got.degen);
          errors++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $display("%0t: pad bits: expected 0 actual %b", $time, m_tdata[7:2]);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;
    test_directed();
    test_tolerance_sweep();
    test_random();
    drain();
    $display("Checked %0d of %0d words: %0d inside, %0d flat, tolerance 0 to max.",
             words_checked, words_sent, inside_seen, degen_seen);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/pit_pkg.sv
design/point_in_tetrahedron_test.sv
design/pit_checker.sv
tb/sv/tb_top.sv
